>>> hdl/icrg_pkg.sv
// Shared types, constants and geometry helpers of the icon line run generator.
package icrg_pkg;

	localparam int ICON_ROWS = 16;
	localparam int ROW_AW = $clog2(ICON_ROWS);
	localparam int STEP_W = $clog2(ROW_AW);
	localparam int CELLS = 16;
	localparam int CELL_W = $clog2(CELLS);
	localparam int QDEPTH = 2;
	localparam int S_TDATA_W = 32;
	localparam int REG_AW = 5;

	localparam logic [2:0] REG_ICON_WIDTH = 3'd0;
	localparam logic [2:0] REG_ICON_HEIGHT = 3'd1;
	localparam logic [2:0] REG_OFFSET_X = 3'd2;
	localparam logic [2:0] REG_OFFSET_Y = 3'd3;
	localparam logic [2:0] REG_SCALE_W = 3'd4;
	localparam logic [2:0] REG_SCALE_H = 3'd5;
	localparam logic [2:0] REG_BORDER_EN = 3'd6;

	localparam logic [1:0] SEL_BG = 2'd0;
	localparam logic [1:0] SEL_FG = 2'd1;
	localparam logic [1:0] SEL_TOP = 2'd2;
	localparam logic [1:0] SEL_BOT = 2'd3;

	localparam logic REQ_LOAD = 1'b0;

	typedef enum logic [1:0] {
		KIND_LOAD = 2'd0,
		KIND_BG = 2'd1,
		KIND_ICON = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] icon_width;
		logic [7:0] icon_height;
		logic [7:0] offset_x;
		logic [7:0] offset_y;
		logic [3:0] scale_w;
		logic [3:0] scale_h;
		logic border_enable;
	} cfg_t;

	typedef struct packed {
		kind_t kind;
		logic [3:0] row_index;
		logic [15:0] row_bits;
		logic [7:0] line_r;
	} qent_t;

	function automatic logic [7:0] centre(input logic [7:0] win, input logic [7:0] size,
			input logic [7:0] shift);
		logic [8:0] d;
		d = {1'b1, win} - {1'b0, size};
		return d[8:1] + 8'd128 + shift;
	endfunction

endpackage

>>> hdl/icrg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module icrg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/icrg_front.sv
// Front end: accepts request words and classifies them as load, background line or icon line.
module icrg_front (
	input icrg_pkg::cfg_t cfg,
	input logic s_tvalid,
	output logic s_tready,
	input logic [icrg_pkg::S_TDATA_W-1:0] s_tdata, // row_index, row_bits, line_y
	input logic s_tuser,                           // req_type
	input logic full,
	output logic push,
	output icrg_pkg::qent_t push_data
);
	import icrg_pkg::*;

	logic [3:0] row_index;
	logic [15:0] row_bits;
	logic [7:0] line_y;
	logic [11:0] bh_full;
	logic [7:0] bh;
	logic [7:0] by;
	logic [7:0] r;
	logic in_icon;
	logic keep;

	always_comb begin
		row_index = s_tdata[3:0];
		row_bits = s_tdata[19:4];
		line_y = s_tdata[27:20];
		bh_full = 12'(ICON_ROWS) * {8'd0, cfg.scale_h};
		bh = bh_full[7:0];
		by = centre(cfg.icon_height, bh, cfg.offset_y);
		r = line_y - by;
		in_icon = (line_y >= by) && (r < bh);
		keep = 1'b1;
		push_data.row_index = row_index;
		push_data.row_bits = row_bits;
		push_data.line_r = r;
		if (s_tuser == REQ_LOAD) begin
			push_data.kind = KIND_LOAD;
			// drop rows beyond the bitmap
			keep = ({1'b0, row_index} < 5'(ICON_ROWS));
		end else if (in_icon) begin
			push_data.kind = KIND_ICON;
		end else begin
			push_data.kind = KIND_BG;
		end
	end

	assign s_tready = !full;
	assign push = s_tvalid && !full && keep;

endmodule

>>> hdl/icrg_fifo.sv
// Short queue of classified requests between front and back end.
module icrg_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input icrg_pkg::qent_t push_data,
	output logic full,
	input logic pop,
	output icrg_pkg::qent_t pop_data,
	output logic empty
);
	import icrg_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	qent_t mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data = mem_q[rd_ptr_q];
	assign full = (count_q == CNT_W'(QDEPTH));
	assign empty = (count_q == '0);

endmodule

>>> hdl/icrg_back.sv
// Back end: stores rows, divides the line offset, fetches rows and emits colour runs.
module icrg_back (
	input logic clk,
	input logic arst_n,
	input icrg_pkg::cfg_t cfg,
	input logic empty,
	input icrg_pkg::qent_t pop_data,
	output logic pop,
	output logic ram_we,
	output logic [icrg_pkg::ROW_AW-1:0] ram_waddr,
	output logic [15:0] ram_wdata,
	output logic [icrg_pkg::ROW_AW-1:0] ram_raddr,
	input logic [15:0] ram_rdata,
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata, // run_length
	output logic [1:0] m_tuser, // color_sel
	output logic m_tlast        // last_run
);
	import icrg_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_BGL  = 10'b0000000010,
		ST_DIV  = 10'b0000000100,
		ST_RD0  = 10'b0000001000,
		ST_RD1  = 10'b0000010000,
		ST_RD2  = 10'b0000100000,
		ST_RD3  = 10'b0001000000,
		ST_LPAD = 10'b0010000000,
		ST_CELL = 10'b0100000000,
		ST_RPAD = 10'b1000000000
	} state_t;

	state_t state_q;
	state_t next_state;

	logic [7:0] rem_q;
	logic [ROW_AW-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic [15:0] cur_q;
	logic [15:0] prv_q;
	logic [15:0] nxt_q;
	logic left_q;
	logic [CELL_W-1:0] cell_q;
	logic [1:0] sub_q;

	logic mvalid_q;
	logic [7:0] run_q;
	logic [1:0] sel_q;
	logic last_q;

	logic [7:0] bw;
	logic [7:0] bx;
	logic [7:0] bx2;
	logic rpad_v;
	logic [7:0] dsh;
	logic first_sub;
	logic last_sub;

	logic [1:0] rsel [3];
	logic [3:0] rlen [3];
	logic [1:0] rcnt;
	logic cell_done;

	logic emit_v;
	logic [1:0] emit_sel;
	logic [7:0] emit_len;
	logic emit_last;
	logic out_free;
	logic advance;

	always_comb begin
		bw = {cfg.scale_w, 4'd0};
		bx = centre(cfg.icon_width, bw, cfg.offset_x);
		bx2 = bx + bw;
		rpad_v = bx2 < cfg.icon_width;
		dsh = 8'({4'd0, cfg.scale_h} << step_q);
		first_sub = (rem_q == 8'd0);
		last_sub = (rem_q == {4'd0, cfg.scale_h - 4'd1});
	end

	// decode the runs of the current cell
	always_comb begin
		rcnt = 2'd1;
		for (int i = 0; i < 3; i++) begin
			rsel[i] = SEL_BG;
			rlen[i] = cfg.scale_w;
		end
		if (!cur_q[15]) begin
			rsel[0] = SEL_BG;
		end else if (!cfg.border_enable) begin
			rsel[0] = SEL_FG;
		end else if (!prv_q[15]) begin
			rsel[0] = SEL_TOP;
		end else if (!nxt_q[15]) begin
			rsel[0] = SEL_BOT;
		end else if (left_q && cur_q[14]) begin
			rsel[0] = SEL_FG;
		end else if (left_q) begin
			if (cfg.scale_w == 4'd1) begin
				rsel[0] = SEL_BOT;
				rlen[0] = 4'd1;
			end else begin
				rsel[0] = SEL_FG;
				rlen[0] = cfg.scale_w - 4'd1;
				rsel[1] = SEL_BOT;
				rlen[1] = 4'd1;
				rcnt = 2'd2;
			end
		end else if (cur_q[14]) begin
			rsel[0] = SEL_TOP;
			rlen[0] = 4'd1;
			if (cfg.scale_w != 4'd1) begin
				rsel[1] = SEL_FG;
				rlen[1] = cfg.scale_w - 4'd1;
				rcnt = 2'd2;
			end
		end else begin
			rsel[0] = SEL_TOP;
			rlen[0] = 4'd1;
			if (cfg.scale_w == 4'd2) begin
				rsel[1] = SEL_BOT;
				rlen[1] = 4'd1;
				rcnt = 2'd2;
			end else if (cfg.scale_w > 4'd2) begin
				rsel[1] = SEL_FG;
				rlen[1] = cfg.scale_w - 4'd2;
				rsel[2] = SEL_BOT;
				rlen[2] = 4'd1;
				rcnt = 2'd3;
			end
		end
		cell_done = (sub_q == rcnt - 2'd1);
	end

	assign out_free = !mvalid_q || m_tready;
	assign advance = !emit_v || out_free;

	always_comb begin
		next_state = state_q;
		pop = 1'b0;
		ram_we = 1'b0;
		ram_waddr = pop_data.row_index[ROW_AW-1:0];
		ram_wdata = pop_data.row_bits;
		ram_raddr = quo_q;
		emit_v = 1'b0;
		emit_sel = SEL_BG;
		emit_len = 8'd0;
		emit_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					case (pop_data.kind)
						KIND_LOAD: ram_we = 1'b1;
						KIND_BG: next_state = ST_BGL;
						KIND_ICON: next_state = ST_DIV;
						default: next_state = ST_IDLE;
					endcase
				end
			end
			ST_BGL: begin
				emit_v = (cfg.icon_width != 8'd0);
				emit_len = cfg.icon_width;
				emit_last = 1'b1;
				if (advance) begin
					next_state = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (step_q == '0) begin
					next_state = ST_RD0;
				end
			end
			ST_RD0: next_state = ST_RD1;
			ST_RD1: begin
				ram_raddr = quo_q - 1'b1;
				next_state = ST_RD2;
			end
			ST_RD2: begin
				ram_raddr = quo_q + 1'b1;
				next_state = ST_RD3;
			end
			ST_RD3: next_state = ST_LPAD;
			ST_LPAD: begin
				emit_v = (bx != 8'd0);
				emit_len = bx;
				emit_last = (cfg.scale_w == 4'd0) && !rpad_v;
				if (advance) begin
					next_state = (cfg.scale_w == 4'd0) ? ST_RPAD : ST_CELL;
				end
			end
			ST_CELL: begin
				emit_v = 1'b1;
				emit_sel = rsel[sub_q];
				emit_len = {4'd0, rlen[sub_q]};
				emit_last = (cell_q == CELL_W'(CELLS - 1)) && cell_done && !rpad_v;
				if (advance && cell_done && cell_q == CELL_W'(CELLS - 1)) begin
					next_state = ST_RPAD;
				end
			end
			ST_RPAD: begin
				emit_v = rpad_v;
				emit_len = cfg.icon_width - bx2;
				emit_last = 1'b1;
				if (advance) begin
					next_state = ST_IDLE;
				end
			end
			default: next_state = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mvalid_q <= 1'b0;
		end else begin
			state_q <= next_state;
			if (emit_v && out_free) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_v && out_free) begin
			run_q <= emit_len;
			sel_q <= emit_sel;
			last_q <= emit_last;
		end
		case (state_q)
			ST_IDLE: begin
				rem_q <= pop_data.line_r;
				quo_q <= '0;
				step_q <= STEP_W'(ROW_AW - 1);
			end
			ST_DIV: begin
				if (rem_q >= dsh) begin
					rem_q <= rem_q - dsh;
					quo_q[step_q] <= 1'b1;
				end
				step_q <= step_q - 1'b1;
			end
			ST_RD1: cur_q <= ram_rdata;
			ST_RD2: prv_q <= first_sub ? ((quo_q == '0) ? 16'd0 : ram_rdata) : cur_q;
			ST_RD3: begin
				nxt_q <= last_sub ?
					((quo_q == ROW_AW'(ICON_ROWS - 1)) ? 16'd0 : ram_rdata) : cur_q;
				cell_q <= '0;
				sub_q <= 2'd0;
				left_q <= 1'b0;
			end
			ST_CELL: begin
				if (advance) begin
					if (cell_done) begin
						sub_q <= 2'd0;
						left_q <= cur_q[15];
						cur_q <= {cur_q[14:0], 1'b0};
						prv_q <= {prv_q[14:0], 1'b0};
						nxt_q <= {nxt_q[14:0], 1'b0};
						cell_q <= cell_q + 1'b1;
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata = run_q;
	assign m_tuser = sel_q;
	assign m_tlast = last_q;

endmodule

>>> hdl/icon_line_run_generator_unit.sv
// Top level of the icon line run generator: register file, front end, queue, back end, row store.
// A load word is queued when taken and written to the row store when the back end pops it while idle.
// A background line gives a single run of the icon width, or none when the width is zero.
// An icon line leaves the queue, takes four division steps and passes the four row-store read states,
// then gives one run per cycle while the output is not stalled; a pad state with an empty pad gives no run.
// The back-end sequencer sets throughput; the queue lets the front take words meanwhile.
// Reset restores register defaults and empties the queue and output; the row store is not cleared.
module icon_line_run_generator_unit (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [icrg_pkg::S_TDATA_W-1:0] s_tdata, // row_index, row_bits, line_y
	input logic s_tuser,                           // req_type
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata, // run_length
	output logic [1:0] m_tuser, // color_sel
	output logic m_tlast,       // last_run
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [icrg_pkg::REG_AW-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import icrg_pkg::*;

	cfg_t cfg_q;
	logic [2:0] reg_idx;
	logic push;
	qent_t push_data;
	logic full;
	logic pop;
	qent_t pop_data;
	logic empty;
	logic ram_we;
	logic [ROW_AW-1:0] ram_waddr;
	logic [15:0] ram_wdata;
	logic [ROW_AW-1:0] ram_raddr;
	logic [15:0] ram_rdata;

	assign pready = 1'b1;
	assign reg_idx = paddr[REG_AW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.icon_width <= 8'd32;
			cfg_q.icon_height <= 8'd32;
			cfg_q.offset_x <= 8'd0;
			cfg_q.offset_y <= 8'd0;
			cfg_q.scale_w <= 4'd1;
			cfg_q.scale_h <= 4'd1;
			cfg_q.border_enable <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_ICON_WIDTH: cfg_q.icon_width <= pwdata[7:0];
				REG_ICON_HEIGHT: cfg_q.icon_height <= pwdata[7:0];
				REG_OFFSET_X: cfg_q.offset_x <= pwdata[7:0];
				REG_OFFSET_Y: cfg_q.offset_y <= pwdata[7:0];
				REG_SCALE_W: cfg_q.scale_w <= pwdata[3:0];
				REG_SCALE_H: cfg_q.scale_h <= pwdata[3:0];
				REG_BORDER_EN: cfg_q.border_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ICON_WIDTH: prdata = {24'd0, cfg_q.icon_width};
			REG_ICON_HEIGHT: prdata = {24'd0, cfg_q.icon_height};
			REG_OFFSET_X: prdata = {24'd0, cfg_q.offset_x};
			REG_OFFSET_Y: prdata = {24'd0, cfg_q.offset_y};
			REG_SCALE_W: prdata = {28'd0, cfg_q.scale_w};
			REG_SCALE_H: prdata = {28'd0, cfg_q.scale_h};
			REG_BORDER_EN: prdata = {31'd0, cfg_q.border_enable};
			default: prdata = 32'd0;
		endcase
	end

	icrg_front u_front (
		.cfg(cfg_q),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.full(full),
		.push(push),
		.push_data(push_data)
	);

	icrg_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(full),
		.pop(pop),
		.pop_data(pop_data),
		.empty(empty)
	);

	icrg_ram #(
		.WIDTH(16),
		.DEPTH(ICON_ROWS)
	) u_row_store (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	icrg_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.empty(empty),
		.pop_data(pop_data),
		.pop(pop),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

endmodule

>>> tb/sv/icrg_run_checker.sv
// Run checker for the icon line run generator: mirrors registers and bitmap, predicts and compares.
module icrg_run_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [icrg_pkg::S_TDATA_W-1:0] s_tdata, // row_index, row_bits, line_y
	input logic s_tuser,                           // req_type
	input logic m_tvalid,
	input logic m_tready,
	input logic [7:0] m_tdata, // run_length
	input logic [1:0] m_tuser, // color_sel
	input logic m_tlast,       // last_run
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [icrg_pkg::REG_AW-1:0] paddr,
	input logic [31:0] pwdata,
	input logic pready,
	output int errors,
	output int pending
);
	import icrg_pkg::*;

	localparam int MAX_RUNS = 50;

	typedef struct packed {
		logic [1:0] sel;
		logic [7:0] len;
		logic last;
	} run_t;

	logic [7:0] win_w, win_h, shift_x, shift_y;
	logic [3:0] cell_w, cell_h;
	logic bevel;
	logic [15:0] bitmap [ICON_ROWS];
	run_t runs_due [$];
	int line_runs;
	int fail_count;

	function automatic logic [7:0] place(input logic [7:0] win, input logic [7:0] span,
			input logic [7:0] shift);
		int slack;
		slack = int'(win) - int'(span);
		return 8'((slack >>> 1) + int'(shift));
	endfunction

	function automatic logic [15:0] row_at(input int row);
		return (row >= 0 && row < ICON_ROWS) ? bitmap[row] : 16'd0;
	endfunction

	function automatic void add_run(input logic [1:0] sel, input logic [7:0] len);
		if (len != 8'd0 && line_runs < MAX_RUNS) begin
			runs_due.push_back(run_t'{sel, len, 1'b0});
			line_runs++;
		end
	endfunction

	function automatic void predict_line(input logic [7:0] ly);
		logic [7:0] span_x, span_y, x0, x1, y0, rel, fill;
		logic [15:0] cur, above, below;
		logic lft, here, rgt;
		int row, sub;
		run_t tail;
		line_runs = 0;
		span_x = {cell_w, 4'd0};
		span_y = {cell_h, 4'd0};
		x0 = place(win_w, span_x, shift_x);
		x1 = x0 + span_x;
		y0 = place(win_h, span_y, shift_y);
		rel = ly - y0;
		if (ly < y0 || rel >= span_y || cell_h == 4'd0) begin
			add_run(SEL_BG, win_w);
		end else begin
			row = int'(rel) / int'(cell_h);
			sub = int'(rel) % int'(cell_h);
			cur = row_at(row);
			above = (sub == 0) ? row_at(row - 1) : cur;
			below = (sub == int'(cell_h) - 1) ? row_at(row + 1) : cur;
			fill = {4'd0, cell_w};
			lft = 1'b0;
			add_run(SEL_BG, x0);
			for (int c = 15; c >= 0; c--) begin
				here = cur[c];
				rgt = (c > 0) ? cur[c-1] : 1'b0;
				if (cell_w != 4'd0) begin
					if (!here) begin
						add_run(SEL_BG, fill);
					end else if (!bevel) begin
						add_run(SEL_FG, fill);
					end else if (!above[c]) begin
						add_run(SEL_TOP, fill);
					end else if (!below[c]) begin
						add_run(SEL_BOT, fill);
					end else if (lft && rgt) begin
						add_run(SEL_FG, fill);
					end else if (lft) begin
						add_run(SEL_FG, fill - 8'd1);
						add_run(SEL_BOT, 8'd1);
					end else if (rgt) begin
						add_run(SEL_TOP, 8'd1);
						add_run(SEL_FG, fill - 8'd1);
					end else begin
						add_run(SEL_TOP, 8'd1);
						if (cell_w > 4'd1) begin
							add_run(SEL_FG, fill - 8'd2);
							add_run(SEL_BOT, 8'd1);
						end
					end
				end
				lft = here;
			end
			if (x1 < win_w)
				add_run(SEL_BG, win_w - x1);
		end
		if (line_runs > 0) begin
			tail = runs_due.pop_back();
			tail.last = 1'b1;
			runs_due.push_back(tail);
		end
	endfunction

	task automatic check_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			fail_count++;
			$error("%s mismatch: expected %0d, actual %0d", field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		run_t due;
		if (!arst_n) begin
			win_w = 8'd32;
			win_h = 8'd32;
			shift_x = 8'd0;
			shift_y = 8'd0;
			cell_w = 4'd1;
			cell_h = 4'd1;
			bevel = 1'b0;
			runs_due.delete();
			fail_count = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
				REG_ICON_WIDTH: win_w = pwdata[7:0];
				REG_ICON_HEIGHT: win_h = pwdata[7:0];
				REG_OFFSET_X: shift_x = pwdata[7:0];
				REG_OFFSET_Y: shift_y = pwdata[7:0];
				REG_SCALE_W: cell_w = pwdata[3:0];
				REG_SCALE_H: cell_h = pwdata[3:0];
				REG_BORDER_EN: bevel = pwdata[0];
				default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (runs_due.size() == 0) begin
					fail_count++;
					$error("run with no line pending: color_sel %0d, run_length %0d",
						m_tuser, m_tdata);
				end else begin
					due = runs_due.pop_front();
					check_field("color_sel", {6'd0, due.sel}, {6'd0, m_tuser});
					check_field("run_length", due.len, m_tdata);
					check_field("last_run", {7'd0, due.last}, {7'd0, m_tlast});
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == REQ_LOAD) begin
					if (int'(s_tdata[3:0]) < ICON_ROWS)
						bitmap[s_tdata[3:0]] = s_tdata[19:4];
				end else begin
					predict_line(s_tdata[27:20]);
				end
			end
			errors <= fail_count;
			pending <= runs_due.size();
		end
	end

endmodule

>>> tb/sv/icon_line_run_generator_unit_tb.sv
// Testbench top for the icon line run generator: stimulus, output stalls, watchdog and verdict.
module icon_line_run_generator_unit_tb;
	import icrg_pkg::*;

	localparam logic REQ_DRAW = ~REQ_LOAD;
	localparam int SETTLE_CYCLES = 80;
	localparam int IDLE_LIMIT = 4000;
	localparam int PHASE_ITEMS = 15;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0; // row_index, row_bits, line_y
	logic s_tuser = 1'b0;               // req_type
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata; // run_length
	logic [1:0] m_tuser; // color_sel
	logic m_tlast;       // last_run
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [REG_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	int errors;
	int pending;
	int burst_left = 0;
	int idle_cycles = 0;
	int stall_mode = 0;
	int mode_left = 0;
	logic [7:0] tgt_h = 8'd32;
	logic [7:0] tgt_off_y = 8'd0;
	logic [3:0] tgt_scale_h = 4'd1;
	logic [15:0] row_art [16] = '{
		16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'hAAAA, 16'h5555, 16'h7FFE, 16'h0FF0,
		16'h3C3C, 16'h1818, 16'hFFFF, 16'hC003, 16'h8001, 16'hE7E7, 16'h0000, 16'hFFFF
	};

	initial begin
		forever #2 clk = ~clk;
	end

	icon_line_run_generator_unit u_top (.*);

	icrg_run_checker u_check (.*);

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				mode_left <= $urandom_range(16, 96);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			default: m_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(psel && penable && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic push_word(input logic req, input logic [3:0] idx, input logic [15:0] bits,
			input logic [7:0] ly);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) :
				$urandom_range(1, 6);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {4'd0, ly, bits, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
	endtask

	task automatic load_row(input logic [3:0] idx, input logic [15:0] bits);
		push_word(REQ_LOAD, idx, bits, 8'($urandom_range(0, 255)));
	endtask

	task automatic draw_line(input logic [7:0] ly);
		push_word(REQ_DRAW, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)), ly);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		logic [31:0] keep;
		keep = (idx == REG_SCALE_W || idx == REG_SCALE_H) ? 32'hF :
			(idx == REG_BORDER_EN) ? 32'h1 : 32'hFF;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= ($urandom() & ~keep) | ({24'd0, val} & keep);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
		REG_ICON_HEIGHT: tgt_h = val;
		REG_OFFSET_Y: tgt_off_y = val;
		REG_SCALE_H: tgt_scale_h = val[3:0];
		default: ;
		endcase
	endtask

	task automatic set_config(input logic [7:0] w, input logic [7:0] h, input logic [7:0] ox,
			input logic [7:0] oy, input logic [3:0] sw, input logic [3:0] sh, input logic be);
		write_reg(REG_ICON_WIDTH, w);
		write_reg(REG_ICON_HEIGHT, h);
		write_reg(REG_OFFSET_X, ox);
		write_reg(REG_OFFSET_Y, oy);
		write_reg(REG_SCALE_W, {4'd0, sw});
		write_reg(REG_SCALE_H, {4'd0, sh});
		write_reg(REG_BORDER_EN, {7'd0, be});
	endtask

	// drop valid, drain every pending run, then let the back end settle
	task automatic quiesce();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_item();
		logic [15:0] bits;
		int y0;
		if ($urandom_range(0, 4) == 0) begin
			case ($urandom_range(0, 2))
			0: bits = 16'($urandom_range(0, 65535));
			1: bits = 16'($urandom_range(0, 65535) | $urandom_range(0, 65535));
			default: bits = 16'($urandom_range(0, 65535) & $urandom_range(0, 65535));
			endcase
			load_row(4'($urandom_range(0, 15)), bits);
		end else if ($urandom_range(0, 3) != 0) begin
			// aim inside the icon rows
			y0 = ((int'(tgt_h) - 16 * int'(tgt_scale_h)) >>> 1) + int'(tgt_off_y);
			draw_line(8'(y0 + int'($urandom_range(0, 16 * int'(tgt_scale_h) - 1))));
		end else begin
			draw_line(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (row_art[i]) load_row(4'(i), row_art[i]);
		draw_line(8'd0);
		draw_line(8'd255);
		draw_line(8'd8);
		draw_line(8'd23);

		quiesce();
		set_config(8'd80, 8'd40, 8'd0, 8'd0, 4'd3, 4'd2, 1'b1);
		draw_line(8'd4);
		draw_line(8'd5);
		draw_line(8'd6);
		draw_line(8'd7);
		draw_line(8'd20);
		draw_line(8'd35);

		quiesce();
		set_config(8'd255, 8'd255, 8'd255, 8'd255, 4'd15, 4'd15, 1'b1);
		repeat (PHASE_ITEMS) random_item();
		quiesce();
		set_config(8'd1, 8'd1, 8'd0, 8'd0, 4'd1, 4'd1, 1'b1);
		repeat (PHASE_ITEMS) random_item();
		quiesce();
		set_config(8'd128, 8'd200, 8'd16, 8'd250, 4'd2, 4'd3, 1'b1);
		repeat (PHASE_ITEMS) random_item();
		quiesce();
		set_config(8'd200, 8'd100, 8'd0, 8'd128, 4'd8, 4'd1, 1'b0);
		repeat (PHASE_ITEMS) random_item();

		repeat (4) begin
			quiesce();
			set_config(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				4'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 15)),
				4'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 15)),
				1'($urandom_range(0, 3) != 0));
			repeat (PHASE_ITEMS) random_item();
		end

		quiesce();
		if (errors == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
hdl/icrg_pkg.sv
hdl/icrg_ram.sv
hdl/icrg_front.sv
hdl/icrg_fifo.sv
hdl/icrg_back.sv
hdl/icon_line_run_generator_unit.sv
tb/sv/icrg_run_checker.sv
tb/sv/icon_line_run_generator_unit_tb.sv
